/* hw/rtl/roslab_pkg.sv */
package roslab_pkg;

  localparam int DATA_W = 32;

  // configuration register indexes
  localparam logic [2:0] REG_ORG_X    = 3'd0;
  localparam logic [2:0] REG_ORG_Y    = 3'd1;
  localparam logic [2:0] REG_ORG_Z    = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_FAR      = 3'd6;
  localparam logic [2:0] REG_EPS      = 3'd7;

  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  localparam logic signed [31:0] RST_DIR_Z = 32'sd4096;
  localparam logic [30:0]        RST_FAR   = 31'd409600000;
  localparam logic [30:0]        RST_EPS   = 31'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CHK,
    S_DIV1,
    S_DIV2,
    S_UPD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/roslab_div.sv */
module roslab_div #(
  parameter int NUM_W = 45
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [NUM_W-1:0]         num,
  input  logic signed [31:0]              den,
  output roslab_pkg::div_stat_t           stat,
  output logic signed [31:0]              quot
);

  localparam int DW    = NUM_W + (NUM_W % 2);
  localparam int STEPS = DW / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvd;
  logic [31:0]      rem;
  logic [31:0]      dsr;
  logic             neg;

  logic [NUM_W-1:0] num_mag;
  logic [31:0]      den_mag;
  logic [DW-1:0]    dvd_next;
  logic [31:0]      rem_next;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);

  // two restoring steps per cycle, quotient bits shift into dvd
  always_comb begin
    logic [32:0] r;
    dvd_next = dvd;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      r = {rem_next, dvd_next[DW-1]};
      dvd_next = {dvd_next[DW-2:0], 1'b0};
      if (r >= {1'b0, dsr}) begin
        r = r - {1'b0, dsr};
        dvd_next[0] = 1'b1;
      end
      rem_next = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DW'(num_mag);
      rem <= '0;
      dsr <= den_mag;
      neg <= num[NUM_W-1] ^ den[31];
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // sign and saturate the truncated magnitude
  always_comb begin
    if (!neg) begin
      quot = (|dvd[DW-1:31]) ? roslab_pkg::S32_MAX : $signed(dvd[31:0]);
    end else if ((|dvd[DW-1:32]) || (dvd[31] && (|dvd[30:0]))) begin
      quot = roslab_pkg::S32_MIN;
    end else begin
      quot = $signed(-dvd[31:0]);
    end
  end

endmodule

/* hw/rtl/ray_obb_slab_test.sv */
// sequencing: an accepted item runs six multiplies and a parallel check and, unless the axis is
//   near parallel, two divisions and an interval update; an axis after a miss in the same box skips to finish
// one item at a time: in_ready is high only while the sequencer is idle;
//   the time per item is set by the shared multiplier (six products) and the radix-4 divider (two)
// reset: synchronous, clears the sequencer and output, loads register reset values,
//   t_near = 0, t_far = far limit reset value, miss flag clear
module ray_obb_slab_test #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] box_pos_x,
  input  logic signed [31:0] box_pos_y,
  input  logic signed [31:0] box_pos_z,
  input  logic signed [31:0] slab_low,
  input  logic signed [31:0] slab_high,
  input  logic [1:0]         axis_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [31:0] distance
);

  localparam int NUM_W = 33 + FRAC_BITS;
  localparam int ACC_W = 66 - FRAC_BITS;

  roslab_pkg::state_t state, state_next;

  logic signed [31:0] org [0:2];
  logic signed [31:0] dir [0:2];
  logic [30:0]        far_limit;
  logic [30:0]        parallel_eps;

  logic signed [31:0] axis [0:2];
  logic signed [31:0] delta [0:2];
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic [1:0]         idx;

  logic signed [31:0] t_near;
  logic signed [31:0] t_far;
  logic               missed;

  logic [2:0]         k;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] e;
  logic signed [31:0] f;
  logic signed [31:0] t1;

  logic                  in_acc;
  logic                  out_free;
  logic                  missed_start;
  logic signed [31:0]    delta_in [0:2];
  logic signed [31:0]    pos_in [0:2];
  logic signed [31:0]    axis_in [0:2];
  logic [1:0]            j;
  logic signed [31:0]    op_a;
  logic signed [31:0]    op_b;
  logic signed [63:0]    prod_sh;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [31:0]    acc_sat;
  logic [32:0]           f_abs;
  logic                  steep;
  logic                  div_start;
  logic signed [NUM_W-1:0] div_num;
  roslab_pkg::div_stat_t div_stat;
  logic signed [31:0]    quot;
  logic signed [31:0]    tmin;
  logic signed [31:0]    tmax;
  logic signed [31:0]    t_far_upd;
  logic signed [31:0]    t_near_upd;

  assign in_ready     = (state == roslab_pkg::S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign missed_start = (axis_index == roslab_pkg::AXIS_FIRST) ? 1'b0 : missed;

  assign pos_in[0]  = box_pos_x;
  assign pos_in[1]  = box_pos_y;
  assign pos_in[2]  = box_pos_z;
  assign axis_in[0] = axis_x;
  assign axis_in[1] = axis_y;
  assign axis_in[2] = axis_z;

  // saturated offset from ray origin to box position
  always_comb begin
    logic signed [32:0] d;
    for (int i = 0; i < 3; i++) begin
      d = {pos_in[i][31], pos_in[i]} - {org[i][31], org[i]};
      if (d[32] != d[31]) begin
        delta_in[i] = d[32] ? roslab_pkg::S32_MIN : roslab_pkg::S32_MAX;
      end else begin
        delta_in[i] = d[31:0];
      end
    end
  end

  // products 0..2 build e, products 3..5 build f
  assign j    = (k < 3'd3) ? k[1:0] : 2'(k - 3'd3);
  assign op_a = (k < 3'd3) ? axis[j] : dir[j];
  assign op_b = (k < 3'd3) ? delta[j] : axis[j];

  assign prod_sh = prod >>> FRAC_BITS;
  assign acc_sum = acc + ACC_W'(prod_sh);
  always_comb begin
    if (acc_sum[ACC_W-1:31] != {(ACC_W - 31){acc_sum[ACC_W-1]}}) begin
      acc_sat = acc_sum[ACC_W-1] ? roslab_pkg::S32_MIN : roslab_pkg::S32_MAX;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  assign f_abs = f[31] ? 33'(-{f[31], f}) : {1'b0, f};
  assign steep = f_abs > {2'b00, parallel_eps};

  assign div_num = (state == roslab_pkg::S_CHK)
                 ? {({e[31], e} + {lo[31], lo}), {FRAC_BITS{1'b0}}}
                 : {({e[31], e} + {hi[31], hi}), {FRAC_BITS{1'b0}}};

  roslab_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (f),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign tmin       = (t1 > quot) ? quot : t1;
  assign tmax       = (t1 > quot) ? t1 : quot;
  assign t_far_upd  = (tmax < t_far) ? tmax : t_far;
  assign t_near_upd = (tmin > t_near) ? tmin : t_near;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= roslab_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      roslab_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = missed_start ? roslab_pkg::S_FIN : roslab_pkg::S_MUL;
        end
      end
      roslab_pkg::S_MUL: state_next = roslab_pkg::S_ACC;
      roslab_pkg::S_ACC: begin
        state_next = (k == 3'd5) ? roslab_pkg::S_CHK : roslab_pkg::S_MUL;
      end
      roslab_pkg::S_CHK: begin
        if (steep) begin
          div_start  = 1'b1;
          state_next = roslab_pkg::S_DIV1;
        end else begin
          state_next = roslab_pkg::S_FIN;
        end
      end
      roslab_pkg::S_DIV1: begin
        if (div_stat.done) begin
          div_start  = 1'b1;
          state_next = roslab_pkg::S_DIV2;
        end
      end
      roslab_pkg::S_DIV2: begin
        if (div_stat.done) begin
          state_next = roslab_pkg::S_UPD;
        end
      end
      roslab_pkg::S_UPD: state_next = roslab_pkg::S_FIN;
      roslab_pkg::S_FIN: begin
        if (idx != roslab_pkg::AXIS_LAST || out_free) begin
          state_next = roslab_pkg::S_IDLE;
        end
      end
      default: state_next = roslab_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
      end
      dir[0]       <= '0;
      dir[1]       <= '0;
      dir[2]       <= roslab_pkg::RST_DIR_Z;
      far_limit    <= roslab_pkg::RST_FAR;
      parallel_eps <= roslab_pkg::RST_EPS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        roslab_pkg::REG_ORG_X: org[0] <= cfg_data;
        roslab_pkg::REG_ORG_Y: org[1] <= cfg_data;
        roslab_pkg::REG_ORG_Z: org[2] <= cfg_data;
        roslab_pkg::REG_DIR_X: dir[0] <= cfg_data;
        roslab_pkg::REG_DIR_Y: dir[1] <= cfg_data;
        roslab_pkg::REG_DIR_Z: dir[2] <= cfg_data;
        roslab_pkg::REG_FAR:   far_limit    <= cfg_data[30:0];
        roslab_pkg::REG_EPS:   parallel_eps <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // slab interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      t_near <= '0;
      t_far  <= $signed({1'b0, roslab_pkg::RST_FAR});
      missed <= 1'b0;
    end else begin
      if (in_acc && axis_index == roslab_pkg::AXIS_FIRST) begin
        t_near <= '0;
        t_far  <= $signed({1'b0, far_limit});
        missed <= 1'b0;
      end
      if (state == roslab_pkg::S_CHK && !steep) begin
        if (lo > e || hi < e) begin
          missed <= 1'b1;
        end
      end
      if (state == roslab_pkg::S_UPD) begin
        t_near <= t_near_upd;
        t_far  <= t_far_upd;
        if (t_far_upd < t_near_upd) begin
          missed <= 1'b1;
        end
      end
    end
  end

  // item capture and dot product datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        axis[i]  <= axis_in[i];
        delta[i] <= delta_in[i];
      end
      lo  <= slab_low;
      hi  <= slab_high;
      idx <= axis_index;
      k   <= '0;
      acc <= '0;
    end
    if (state == roslab_pkg::S_MUL) begin
      prod <= 64'(op_a) * 64'(op_b);
    end
    if (state == roslab_pkg::S_ACC) begin
      k <= k + 3'd1;
      if (k == 3'd2) begin
        e   <= acc_sat;
        acc <= '0;
      end else begin
        acc <= acc_sum;
      end
      if (k == 3'd5) begin
        f <= acc_sat;
      end
    end
    if (state == roslab_pkg::S_DIV1 && div_stat.done) begin
      t1 <= quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == roslab_pkg::S_FIN && idx == roslab_pkg::AXIS_LAST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == roslab_pkg::S_FIN && idx == roslab_pkg::AXIS_LAST && out_free) begin
      hit      <= !missed;
      distance <= missed ? '0 : t_near;
    end
  end

endmodule

/* hw/rtl/roslab_chk.sv */
module roslab_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           hit,
  input logic [roslab_pkg::DATA_W-1:0]  distance
);

  // one item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted item");

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (distance == '0))
    else $error("miss result with nonzero distance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(hit) && $stable(distance)))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ray_obb_slab_test roslab_chk u_roslab_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .distance  (distance)
);
